// ===== rtl/core/fess_pkg.sv =====
package fess_pkg;

  // Default band geometry and cost width.
  localparam int MaxColsDefault  = 512;
  localparam int MaxRowsDefault  = 512;
  localparam int CostBitsDefault = 24;

  // Gray conversion weights, fixed point with 14 fraction bits.
  localparam int GrayWeightB = 1868;
  localparam int GrayWeightG = 9617;
  localparam int GrayWeightR = 4899;
  localparam int GrayRound   = 8192;
  localparam int GrayShift   = 14;
  localparam int GrayBits    = 8;

  // Clamp on each edge cost.
  localparam logic [GrayBits:0] EdgeCostMax = 9'd255;

  // Register indexes of the write port.
  localparam logic [1:0] RegBandCols = 2'd0;
  localparam logic [1:0] RegBandRows = 2'd1;

endpackage

// ===== rtl/core/forward_energy_seam_search.sv =====
// Forward energy vertical seam search over one band of pixels.
// Input stream: each word either loads one pixel (tuser low) or asks for the
// seam column of one row (tuser high). Pixels come row by row, left to right.
// Output stream: one word per answered query, seam column and echoed row.
// A query before a band is finished, or for a row beyond the band, gives no word.
// Configuration: band_cols and band_rows through a plain write port, to be written
// only while the block is idle; each write to either restarts loading at row 0, column 0.
// Sequence: each pixel is written to the gray memory as it is taken. The word that
// completes a row starts a sweep through the cost memory, one column per cycle,
// and no input is taken until it ends. The word that completes the band adds a
// bottom scan and a trace, three reads of the single cost memory read port per row.
// A query reads the seam memory into a register; ST_QRD then loads the output word.
// Reset clears the load position and the seam ready flag; band_cols and
// band_rows return to 512 (or the maximum if smaller). Memories are not cleared.
// A stalled receiver holds the output register; while a word waits there and the
// receiver stalls, no input word of either kind is taken.
module forward_energy_seam_search
  import fess_pkg::*;
#(
  parameter int MAX_COLS  = MaxColsDefault,
  parameter int MAX_ROWS  = MaxRowsDefault,
  parameter int COST_BITS = CostBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // blue[7:0], green[15:8], red[23:16], outside[24], query_row[33:25], zeros
  input  logic [39:0] s_axis_tdata_i,
  // kind
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // seam_col[8:0], row_index[17:9], zeros
  output logic [23:0] m_axis_tdata_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [9:0]  cfg_data_i
);

  localparam int CW  = $clog2(MAX_COLS);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CNW = $clog2(MAX_COLS + 1);
  localparam int RNW = $clog2(MAX_ROWS + 1);
  localparam int ColsReset = (MAX_COLS < 512) ? MAX_COLS : 512;
  localparam int RowsReset = (MAX_ROWS < 512) ? MAX_ROWS : 512;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ROW    = 3'd1;
  localparam logic [2:0] ST_BOTTOM = 3'd2;
  localparam logic [2:0] ST_TRACE  = 3'd3;
  localparam logic [2:0] ST_QRD    = 3'd4;

  // Input word fields.
  logic [7:0] in_blue, in_green, in_red;
  logic       in_outside;
  logic [8:0] in_query;
  assign in_blue    = s_axis_tdata_i[7:0];
  assign in_green   = s_axis_tdata_i[15:8];
  assign in_red     = s_axis_tdata_i[23:16];
  assign in_outside = s_axis_tdata_i[24];
  assign in_query   = s_axis_tdata_i[33:25];

  logic [2:0]           state_q;
  logic [CNW-1:0]       band_cols_q, load_col_q, rd_col_q;
  logic [RNW-1:0]       band_rows_q, load_row_q;
  logic [RW-1:0]        row_q, trace_row_q;
  logic                 bank_q, seam_ready_q;
  logic                 a_valid_q, b_valid_q;
  logic [CNW-1:0]       a_col_q;
  logic [CW-1:0]        b_col_q;
  logic [CW-1:0]        trace_c_q, best_col_q;
  logic [1:0]           phase_q;
  logic [COST_BITS-1:0] best_q, tr_l_q, tr_m_q;
  logic                 out_valid_q;
  logic [8:0]           out_col_q, out_row_q;

  // Memories and their registered read data.
  logic [COST_BITS-1:0] cost_mem [MAX_ROWS << CW];
  logic [GrayBits:0]    gray_mem [2 << CW];
  logic [CW-1:0]        seam_mem [MAX_ROWS];
  logic [COST_BITS-1:0] cost_rd_q;
  logic [GrayBits:0]    gcur_rd_q, gprev_rd_q;
  logic [CW-1:0]        seam_rd_q;

  // Sweep window: left, middle and right columns.
  logic [GrayBits-1:0]  win_gl_q, win_gm_q, win_gr_q, win_pm_q, win_pr_q;
  logic                 win_mm_q, win_mr_q;
  logic [COST_BITS-1:0] win_cl_q, win_cm_q, win_cr_q;

  logic                 in_acc, out_acc, issue_en;
  logic [CW+RW-1:0]     cost_raddr, cost_waddr;
  logic [CNW-1:0]       col_eff, col_next, tr_col_wide;
  logic [RNW-1:0]       row_eff;
  logic [RW-1:0]        bottom_row;
  logic [21:0]          gray_sum;
  logic [GrayBits-1:0]  gray_val;
  logic [COST_BITS-1:0] row_best;
  logic                 sw_first, sw_l_ok, sw_r_ok, sw_last;
  logic [GrayBits-1:0]  sw_gl, sw_gr;
  logic                 bot_take;
  logic [CW-1:0]        bot_col;
  logic                 tr_l_ok, tr_r_ok;
  logic [COST_BITS-1:0] tr_min_lm, tr_min;
  logic [CW-1:0]        tr_pick;
  logic [9:0]           cfg_cols_v, cfg_rows_v;

  assign s_axis_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc         = out_valid_q && m_axis_tready_i;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_row_q, out_col_q};

  assign bottom_row = RW'(band_rows_q - RNW'(1));

  // Pixel position, wrapped to the band start when out of range.
  always_comb begin
    if (load_col_q >= band_cols_q || load_row_q >= band_rows_q) begin
      col_eff = '0;
      row_eff = '0;
    end else begin
      col_eff = load_col_q;
      row_eff = load_row_q;
    end
    col_next = col_eff + CNW'(1);
  end

  // Weighted gray conversion.
  always_comb begin
    gray_sum = 22'(GrayWeightB) * 22'(in_blue) + 22'(GrayWeightG) * 22'(in_green)
             + 22'(GrayWeightR) * 22'(in_red) + 22'(GrayRound);
    gray_val = (gray_sum[21:GrayShift] > 8'd255) ? 8'd255 : gray_sum[GrayShift+GrayBits-1:GrayShift];
  end

  // Configuration values, clamped to the legal range.
  always_comb begin
    cfg_cols_v = cfg_data_i;
    cfg_rows_v = cfg_data_i;
    if (cfg_data_i < 10'd3) begin
      cfg_cols_v = 10'd3;
    end else if (32'(cfg_data_i) > MAX_COLS) begin
      cfg_cols_v = 10'(MAX_COLS);
    end
    if (cfg_data_i < 10'd2) begin
      cfg_rows_v = 10'd2;
    end else if (32'(cfg_data_i) > MAX_ROWS) begin
      cfg_rows_v = 10'(MAX_ROWS);
    end
  end

  // Read issue for the row sweep and the bottom scan.
  always_comb begin
    issue_en = 1'b0;
    if (state_q == ST_ROW) begin
      issue_en = (rd_col_q <= band_cols_q);
    end else if (state_q == ST_BOTTOM) begin
      issue_en = (rd_col_q < band_cols_q);
    end
  end

  assign tr_col_wide = CNW'(trace_c_q) + CNW'(phase_q) - CNW'(1);

  // Cost memory read address.
  always_comb begin
    case (state_q)
      ST_BOTTOM: cost_raddr = {bottom_row, rd_col_q[CW-1:0]};
      ST_TRACE:  cost_raddr = {RW'(trace_row_q - RW'(1)), tr_col_wide[CW-1:0]};
      default:   cost_raddr = {RW'(row_q - RW'(1)), rd_col_q[CW-1:0]};
    endcase
  end

  assign cost_waddr = {row_q, b_col_q};

  // Sweep edges: replicate gray, exclude cost, at the band border.
  always_comb begin
    sw_first = (row_q == '0);
    sw_l_ok  = (b_col_q != '0);
    sw_last  = (CNW'(b_col_q) == band_cols_q - CNW'(1));
    sw_r_ok  = !sw_last;
    sw_gl    = sw_l_ok ? win_gl_q : win_gm_q;
    sw_gr    = sw_r_ok ? win_gr_q : win_gm_q;
  end

  fess_cost_unit #(
    .COST_BITS (COST_BITS)
  ) u_cost (
    .first_row_i (sw_first),
    .masked_i    (win_mm_q),
    .gray_l_i    (sw_gl),
    .gray_r_i    (sw_gr),
    .gray_up_i   (win_pm_q),
    .cost_l_i    (win_cl_q),
    .cost_m_i    (win_cm_q),
    .cost_r_i    (win_cr_q),
    .l_ok_i      (sw_l_ok),
    .r_ok_i      (sw_r_ok),
    .best_o      (row_best)
  );

  // Bottom scan: strict compare keeps the lowest column on ties.
  always_comb begin
    bot_take = (a_col_q == '0) || (cost_rd_q < best_q);
    bot_col  = bot_take ? a_col_q[CW-1:0] : best_col_q;
  end

  // Trace step: left wins ties, then right, then straight.
  always_comb begin
    tr_l_ok   = (trace_c_q != '0);
    tr_r_ok   = (CNW'(trace_c_q) + CNW'(1) < band_cols_q);
    tr_min_lm = (tr_l_ok && tr_l_q < tr_m_q) ? tr_l_q : tr_m_q;
    tr_min    = (tr_r_ok && cost_rd_q < tr_min_lm) ? cost_rd_q : tr_min_lm;
    if (tr_l_ok && tr_l_q == tr_min) begin
      tr_pick = trace_c_q - CW'(1);
    end else if (tr_r_ok && cost_rd_q == tr_min) begin
      tr_pick = trace_c_q + CW'(1);
    end else begin
      tr_pick = trace_c_q;
    end
  end

  // Cost memory: one read and one write port.
  always_ff @(posedge clk_i) begin
    cost_rd_q <= cost_mem[cost_raddr];
    if (b_valid_q) begin
      cost_mem[cost_waddr] <= row_best;
    end
  end

  // Gray and mask rows, two banks swapped at each row end.
  always_ff @(posedge clk_i) begin
    gcur_rd_q  <= gray_mem[{bank_q, rd_col_q[CW-1:0]}];
    gprev_rd_q <= gray_mem[{~bank_q, rd_col_q[CW-1:0]}];
    if (in_acc && !s_axis_tuser_i) begin
      gray_mem[{bank_q, col_eff[CW-1:0]}] <= {in_outside, gray_val};
    end
  end

  // Seam memory, written by the bottom scan and the trace, read by queries.
  always_ff @(posedge clk_i) begin
    seam_rd_q <= seam_mem[RW'(in_query)];
    if (state_q == ST_BOTTOM && a_valid_q && a_col_q == band_cols_q - CNW'(1)) begin
      seam_mem[bottom_row] <= bot_col;
    end else if (state_q == ST_TRACE && phase_q == 2'd3) begin
      seam_mem[trace_row_q - RW'(1)] <= tr_pick;
    end
  end

  // Sweep pipeline payload.
  always_ff @(posedge clk_i) begin
    if (a_valid_q) begin
      win_gl_q <= win_gm_q;
      win_gm_q <= win_gr_q;
      win_gr_q <= gcur_rd_q[GrayBits-1:0];
      win_mm_q <= win_mr_q;
      win_mr_q <= gcur_rd_q[GrayBits];
      win_pm_q <= win_pr_q;
      win_pr_q <= gprev_rd_q[GrayBits-1:0];
      win_cl_q <= win_cm_q;
      win_cm_q <= win_cr_q;
      win_cr_q <= cost_rd_q;
    end
    b_col_q <= CW'(a_col_q - CNW'(1));
    if (state_q == ST_BOTTOM && a_valid_q) begin
      best_col_q <= bot_col;
      if (bot_take) begin
        best_q <= cost_rd_q;
      end
    end
    if (state_q == ST_TRACE && phase_q == 2'd1) begin
      tr_l_q <= cost_rd_q;
    end
    if (state_q == ST_TRACE && phase_q == 2'd2) begin
      tr_m_q <= cost_rd_q;
    end
    if (state_q == ST_QRD) begin
      out_col_q <= 9'(seam_rd_q);
    end
    if (in_acc && s_axis_tuser_i) begin
      out_row_q <= in_query;
    end
  end

  // Control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      band_cols_q  <= CNW'(ColsReset);
      band_rows_q  <= RNW'(RowsReset);
      load_col_q   <= '0;
      load_row_q   <= '0;
      row_q        <= '0;
      trace_row_q  <= '0;
      trace_c_q    <= '0;
      phase_q      <= '0;
      rd_col_q     <= '0;
      bank_q       <= 1'b0;
      seam_ready_q <= 1'b0;
      a_valid_q    <= 1'b0;
      a_col_q      <= '0;
      b_valid_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      a_valid_q <= issue_en;
      a_col_q   <= rd_col_q;
      b_valid_q <= a_valid_q && (state_q == ST_ROW) && (a_col_q != '0);
      if (issue_en) begin
        rd_col_q <= rd_col_q + CNW'(1);
      end
      if (out_acc) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i && (cfg_idx_i == RegBandCols || cfg_idx_i == RegBandRows)) begin
        if (cfg_idx_i == RegBandCols) begin
          band_cols_q <= CNW'(cfg_cols_v);
        end else begin
          band_rows_q <= RNW'(cfg_rows_v);
        end
        load_col_q   <= '0;
        load_row_q   <= '0;
        seam_ready_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc && !s_axis_tuser_i) begin
            seam_ready_q <= 1'b0;
            load_row_q   <= row_eff;
            if (col_next >= band_cols_q) begin
              load_col_q <= '0;
              row_q      <= RW'(row_eff);
              rd_col_q   <= '0;
              state_q    <= ST_ROW;
            end else begin
              load_col_q <= col_next;
            end
          end else if (in_acc && seam_ready_q && 10'(in_query) < 10'(band_rows_q)) begin
            state_q <= ST_QRD;
          end
        end
        ST_ROW: begin
          if (b_valid_q && sw_last) begin
            bank_q <= ~bank_q;
            if (RNW'(row_q) + RNW'(1) >= band_rows_q) begin
              load_row_q <= '0;
              rd_col_q   <= '0;
              state_q    <= ST_BOTTOM;
            end else begin
              load_row_q <= RNW'(row_q) + RNW'(1);
              state_q    <= ST_IDLE;
            end
          end
        end
        ST_BOTTOM: begin
          if (a_valid_q && a_col_q == band_cols_q - CNW'(1)) begin
            trace_c_q   <= bot_col;
            trace_row_q <= bottom_row;
            phase_q     <= '0;
            state_q     <= ST_TRACE;
          end
        end
        ST_TRACE: begin
          phase_q <= phase_q + 2'd1;
          if (phase_q == 2'd3) begin
            trace_c_q   <= tr_pick;
            trace_row_q <= trace_row_q - RW'(1);
            if (trace_row_q == RW'(1)) begin
              seam_ready_q <= 1'b1;
              state_q      <= ST_IDLE;
            end
          end
        end
        ST_QRD: begin
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // The cost memory is written only by the row sweep.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> state_q == ST_ROW)
    else $error("cost write outside the row sweep");

  // A finished seam only comes from the trace.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(seam_ready_q) |-> $past(state_q) == ST_TRACE)
    else $error("seam ready set outside the trace");

  // The query read never lands on an occupied output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_QRD |-> !out_valid_q)
    else $error("query result would overwrite a pending word");

  // While idle the load column stays inside the band.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> load_col_q < band_cols_q)
    else $error("load column out of band");

endmodule

// ===== rtl/core/fess_cost_unit.sv =====
module fess_cost_unit
  import fess_pkg::*;
#(
  parameter int COST_BITS = CostBitsDefault
) (
  input  logic                 first_row_i,
  input  logic                 masked_i,
  input  logic [GrayBits-1:0]  gray_l_i,
  input  logic [GrayBits-1:0]  gray_r_i,
  input  logic [GrayBits-1:0]  gray_up_i,
  input  logic [COST_BITS-1:0] cost_l_i,
  input  logic [COST_BITS-1:0] cost_m_i,
  input  logic [COST_BITS-1:0] cost_r_i,
  input  logic                 l_ok_i,
  input  logic                 r_ok_i,
  output logic [COST_BITS-1:0] best_o
);

  localparam logic [COST_BITS-1:0] CostInf = '1;

  logic [GrayBits-1:0]  cu, dl, dr;
  logic [GrayBits:0]    sl, sr, cl, cr;
  logic [COST_BITS:0]   sum_m, sum_l, sum_r;
  logic [COST_BITS-1:0] tot_m, tot_l, tot_r, pick_lm;

  // Forward energy edge costs, the side costs clamped.
  always_comb begin
    cu = (gray_r_i > gray_l_i) ? gray_r_i - gray_l_i : gray_l_i - gray_r_i;
    dl = (gray_up_i > gray_l_i) ? gray_up_i - gray_l_i : gray_l_i - gray_up_i;
    dr = (gray_up_i > gray_r_i) ? gray_up_i - gray_r_i : gray_r_i - gray_up_i;
    sl = {1'b0, dl} + {1'b0, cu};
    sr = {1'b0, dr} + {1'b0, cu};
    cl = (sl > EdgeCostMax) ? EdgeCostMax : sl;
    cr = (sr > EdgeCostMax) ? EdgeCostMax : sr;
  end

  // Saturating sums; a carry out means the sum passed the infinity code.
  always_comb begin
    sum_m = {1'b0, cost_m_i} + (COST_BITS+1)'(cu);
    sum_l = {1'b0, cost_l_i} + (COST_BITS+1)'(cl);
    sum_r = {1'b0, cost_r_i} + (COST_BITS+1)'(cr);
    tot_m = sum_m[COST_BITS] ? CostInf : sum_m[COST_BITS-1:0];
    tot_l = sum_l[COST_BITS] ? CostInf : sum_l[COST_BITS-1:0];
    tot_r = sum_r[COST_BITS] ? CostInf : sum_r[COST_BITS-1:0];
  end

  // Minimum over the predecessors that lie inside the band; a masked pixel costs infinity, the first row zero.
  always_comb begin
    pick_lm = (l_ok_i && tot_l < tot_m) ? tot_l : tot_m;
    if (masked_i) begin
      best_o = CostInf;
    end else if (first_row_i) begin
      best_o = '0;
    end else if (r_ok_i && tot_r < pick_lm) begin
      best_o = tot_r;
    end else begin
      best_o = pick_lm;
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import fess_pkg::*;

  localparam int Cols = MaxColsDefault;
  localparam int Rows = MaxRowsDefault;
  localparam longint CostInf = (64'd1 << CostBitsDefault) - 1;
  // Cycles the block may still spend on a row sweep, bottom scan and trace.
  localparam int DrainCycles = 2 * Cols + 4 * Rows + 32;

  // Indexes that decode to no register.
  localparam logic [1:0] RegSpareA = 2'd2;
  localparam logic [1:0] RegSpareB = 2'd3;

  typedef enum logic {KindPixel = 1'b0, KindQuery = 1'b1} kind_e;

  typedef struct {
    kind_e      kind;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       outside;
    logic [8:0] query_row;
    bit         wait_drain;
  } word_t;

  typedef struct {
    logic [8:0] seam_col;
    logic [8:0] row_index;
  } seam_ans_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [39:0] s_data = '0;
  logic        s_user = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [23:0] m_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [9:0]  cfg_data = '0;

  forward_energy_seam_search i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the block state.
  logic [23:0] cost_map [Rows * Cols];
  logic [7:0]  gray_above [Cols];
  logic [7:0]  gray_row [Cols];
  logic        mask_bits [Cols];
  logic [8:0]  seam_path [Rows];
  int          row_pos, col_pos, band_w, band_h;
  bit          seam_valid;

  word_t     pixel_queue[$];
  seam_ans_t seam_answers[$];
  word_t     cur_word;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        errors = 0;
  int        n_pixels = 0, n_queries = 0, n_answers = 0, n_bands = 0;

  // Append one word to the pending queue.
  function automatic void queue_word(word_t w);
    pixel_queue.insert(pixel_queue.size(), w);
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    return (a + b > CostInf) ? CostInf : a + b;
  endfunction

  function automatic int dist_of(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Cumulative forward energy of one finished row.
  function automatic void close_row(int r);
    int gl, gr, up, cu, cl, cr, base;
    longint best, c;
    for (int j = 0; j < band_w; j++) begin
      if (mask_bits[j]) begin
        best = CostInf;
      end else if (r == 0) begin
        best = 0;
      end else begin
        gl = gray_row[j > 0 ? j - 1 : 0];
        gr = gray_row[j + 1 < band_w ? j + 1 : band_w - 1];
        up = gray_above[j];
        cu = dist_of(gr, gl);
        cl = dist_of(up, gl) + cu;
        cr = dist_of(up, gr) + cu;
        if (cl > 255) cl = 255;
        if (cr > 255) cr = 255;
        base = (r - 1) * Cols;
        best = sat_sum(cost_map[base + j], cu);
        if (j > 0) begin
          c = sat_sum(cost_map[base + j - 1], cl);
          if (c < best) best = c;
        end
        if (j + 1 < band_w) begin
          c = sat_sum(cost_map[base + j + 1], cr);
          if (c < best) best = c;
        end
      end
      cost_map[r * Cols + j] = best[23:0];
    end
    gray_above = gray_row;
  endfunction

  // Cheapest bottom entry, then walk upward preferring left, right, straight.
  function automatic void trace_path();
    int last, best_col, c, base, pick;
    logic [23:0] best, m;
    last = band_h - 1;
    best_col = 0;
    best = cost_map[last * Cols];
    for (int j = 1; j < band_w; j++) begin
      if (cost_map[last * Cols + j] < best) begin
        best = cost_map[last * Cols + j];
        best_col = j;
      end
    end
    seam_path[last] = 9'(best_col);
    for (int r = last; r > 0; r--) begin
      c = seam_path[r];
      base = (r - 1) * Cols;
      m = cost_map[base + c];
      pick = c;
      if (c > 0 && cost_map[base + c - 1] < m) m = cost_map[base + c - 1];
      if (c + 1 < band_w && cost_map[base + c + 1] < m) m = cost_map[base + c + 1];
      if (c > 0 && cost_map[base + c - 1] == m) pick = c - 1;
      else if (c + 1 < band_w && cost_map[base + c + 1] == m) pick = c + 1;
      seam_path[r - 1] = 9'(pick);
    end
  endfunction

  function automatic void predict_word(word_t w);
    int g;
    seam_ans_t a;
    if (w.kind == KindPixel) begin
      g = (GrayWeightB * w.blue + GrayWeightG * w.green + GrayWeightR * w.red
           + GrayRound) >> GrayShift;
      seam_valid = 0;
      if (col_pos >= band_w || row_pos >= band_h) begin
        col_pos = 0;
        row_pos = 0;
      end
      gray_row[col_pos] = (g > 255) ? 8'd255 : g[7:0];
      mask_bits[col_pos] = w.outside;
      col_pos++;
      if (col_pos >= band_w) begin
        close_row(row_pos);
        col_pos = 0;
        row_pos++;
        if (row_pos >= band_h) begin
          trace_path();
          seam_valid = 1;
          row_pos = 0;
          n_bands++;
        end
      end
    end else if (seam_valid && w.query_row < band_h) begin
      a.seam_col = seam_path[w.query_row];
      a.row_index = w.query_row;
      seam_answers.insert(seam_answers.size(), a);
    end
  endfunction

  // Driver: one word at a time from the pending queue.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else if (!s_valid || s_ready) begin
      if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct &&
          !(pixel_queue[0].wait_drain && (s_valid || seam_answers.size() > 0))) begin
        cur_word = pixel_queue.pop_front();
        s_valid <= 1'b1;
        s_user <= cur_word.kind;
        s_data <= {6'b0, cur_word.query_row, cur_word.outside, cur_word.red,
                   cur_word.green, cur_word.blue};
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    m_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: check each answer, then predict from each accepted word.
  always @(posedge clk_i) begin
    word_t w;
    seam_ans_t e;
    if (rst_ni) begin
      if (m_valid && m_ready) begin
        n_answers++;
        if (seam_answers.size() == 0) begin
          $display("%0t: expected no word, actual seam_col=%0d row_index=%0d", $time,
                   m_data[8:0], m_data[17:9]);
          errors++;
        end else begin
          e = seam_answers.pop_front();
          if (m_data[8:0] !== e.seam_col) begin
            $display("%0t: seam_col expected %0d actual %0d (row %0d)", $time,
                     e.seam_col, m_data[8:0], e.row_index);
            errors++;
          end
          if (m_data[17:9] !== e.row_index) begin
            $display("%0t: row_index expected %0d actual %0d", $time,
                     e.row_index, m_data[17:9]);
            errors++;
          end
        end
      end
      if (s_valid && s_ready) begin
        w.kind = kind_e'(s_user);
        w.blue = s_data[7:0];
        w.green = s_data[15:8];
        w.red = s_data[23:16];
        w.outside = s_data[24];
        w.query_row = s_data[33:25];
        w.wait_drain = 0;
        if (w.kind == KindPixel) n_pixels++;
        else n_queries++;
        predict_word(w);
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [9:0] val);
    int v;
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    v = val;
    if (idx == RegBandCols) begin
      band_w = (v < 3) ? 3 : (v > Cols ? Cols : v);
    end else if (idx == RegBandRows) begin
      band_h = (v < 2) ? 2 : (v > Rows ? Rows : v);
    end
    if (idx == RegBandCols || idx == RegBandRows) begin
      row_pos = 0;
      col_pos = 0;
      seam_valid = 0;
    end
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic word_t make_query(int row, bit drain);
    word_t w;
    w.kind = KindQuery;
    w.blue = 8'($urandom_range(255));
    w.green = 8'($urandom_range(255));
    w.red = 8'($urandom_range(255));
    w.outside = 1'($urandom_range(1));
    w.query_row = 9'(row);
    w.wait_drain = drain;
    return w;
  endfunction

  function automatic word_t make_pixel(int b, int g, int r, bit o);
    word_t w;
    w.kind = KindPixel;
    w.blue = 8'(b);
    w.green = 8'(g);
    w.red = 8'(r);
    w.outside = o;
    w.query_row = 9'($urandom_range(511));
    w.wait_drain = 0;
    return w;
  endfunction

  // One full band of random pixels, stray queries, then a burst of queries.
  task automatic add_band();
    int flat, lvl;
    bit flat_band;
    flat_band = ($urandom_range(3) == 0);
    for (int i = 0; i < band_w * band_h; i++) begin
      if ($urandom_range(15) == 0) queue_word(make_query($urandom_range(511), 0));
      if (flat_band) begin
        lvl = $urandom_range(1) ? 255 : 0;
        queue_word(make_pixel(lvl, lvl, lvl, $urandom_range(15) == 0));
      end else begin
        queue_word(make_pixel($urandom_range(255), $urandom_range(255),
                              $urandom_range(255), $urandom_range(7) == 0));
      end
    end
    queue_word(make_query($urandom_range(band_h - 1), 1));
    for (int i = 0; i < band_h && i < 10; i++) begin
      queue_word(make_query($urandom_range(band_h - 1), 0));
    end
    queue_word(make_query(band_h - 1, 0));
    flat = band_h + $urandom_range(3);
    queue_word(make_query(flat > 511 ? 511 : flat, 0));
    queue_word(make_query($urandom_range(511), 0));
  endtask

  task automatic settle();
    while (pixel_queue.size() > 0 || s_valid || seam_answers.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(int cols, int rows, int bands, int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    write_reg(RegBandCols, 10'(cols));
    write_reg(RegBandRows, 10'(rows));
    for (int b = 0; b < bands; b++) add_band();
    settle();
  endtask

  initial begin
    band_w = Cols;
    band_h = Rows;
    row_pos = 0;
    col_pos = 0;
    seam_valid = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: smallest band, written below the floor, with edge colors.
    write_reg(RegBandCols, 10'd0);
    write_reg(RegBandRows, 10'd1);
    queue_word(make_query(0, 0));
    queue_word(make_pixel(255, 255, 255, 0));
    queue_word(make_pixel(0, 0, 0, 0));
    queue_word(make_pixel(255, 0, 0, 1));
    queue_word(make_query(1, 0));
    queue_word(make_pixel(0, 255, 0, 0));
    queue_word(make_pixel(0, 0, 255, 0));
    queue_word(make_pixel(128, 128, 128, 0));
    queue_word(make_query(0, 1));
    queue_word(make_query(1, 0));
    queue_word(make_query(2, 0));
    queue_word(make_query(511, 0));
    // A fully masked band ties everywhere and saturates.
    for (int i = 0; i < 6; i++) queue_word(make_pixel(i * 40, 7, 200, 1));
    queue_word(make_query(0, 1));
    queue_word(make_query(1, 0));
    settle();

    // Writes to unused indexes must leave the band alone.
    write_reg(RegSpareA, 10'd5);
    write_reg(RegSpareB, 10'd1023);
    queue_word(make_query(1, 0));
    settle();

    // Random phases over several geometries and handshake patterns.
    run_phase(5, 4, 3, 0, 0);
    run_phase(8, 6, 2, 53, 0);
    run_phase(3, 2, 4, 0, 53);
    run_phase(16, 10, 1, 22, 22);
    run_phase(7, 3, 3, 0, 53);
    run_phase(12, 12, 1, 22, 22);
    run_phase(4, 9, 3, 0, 0);
    run_phase(6, 5, 3, 22, 22);

    $display("Covered %0d bands over %0d pixel words and %0d queries,", n_bands, n_pixels,
             n_queries);
    $display("with %0d seam answers checked under mixed source and sink stalls.", n_answers);
    if (errors == 0 && seam_answers.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/fess_pkg.sv
rtl/core/fess_cost_unit.sv
rtl/core/forward_energy_seam_search.sv
tb/sv/testbench.sv
